>>> design/see_pkg.sv
package see_pkg;

  localparam int StackDepthDef = 128;
  localparam int DataW         = 32;
  localparam int SymW          = 8;
  localparam int StatW         = 3;

  localparam logic [SymW-1:0] ChZero  = 8'h30;
  localparam logic [SymW-1:0] ChNine  = 8'h39;
  localparam logic [SymW-1:0] ChPlus  = 8'h2B;
  localparam logic [SymW-1:0] ChMinus = 8'h2D;
  localparam logic [SymW-1:0] ChSlash = 8'h2F;
  localparam logic [SymW-1:0] ChStar  = 8'h2A;
  localparam logic [SymW-1:0] ChCaret = 8'h5E;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_INVALID = 3'd3,
    ST_DIVZERO = 3'd4,
    ST_EMPTY   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_LAT, S_EXEC, S_WAIT, S_WB, S_FINRD, S_FINWAIT, S_OUT
  } state_e;

  typedef enum logic [1:0] {A_IDLE, A_DIV, A_POW, A_DONE} alu_e;

  // controller -> datapath
  typedef struct packed {
    logic push_digit;  // write digit at sp, sp++
    logic rd_top;      // read sp-1
    logic rd_second;   // read sp-2, latch previous read as first
    logic latch_second;
    logic start;       // start arithmetic
    logic wb;          // write result at sp-2, sp--
    logic fin_latch;   // capture output value
    logic clear;       // end of expression
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic    done;
    logic    divz;
  } sts_t;

endpackage

>>> design/see_if.sv
interface see_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;
  modport source (output valid, symbol, last, input ready);
  modport sink   (input valid, symbol, last, output ready);
endinterface

interface see_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [2:0]         status;
  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

>>> design/see_alu.sv
module see_alu import see_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  op_e              op_i,
  input  logic [DataW-1:0] left_i,
  input  logic [DataW-1:0] right_i,
  output logic             done_o,
  output logic [DataW-1:0] res_o
);

  alu_e             st_q, st_d;
  logic [DataW-1:0] res_q, res_d;
  logic [DataW-1:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             qneg_q, qneg_d;
  logic [DataW:0]   pacc_q, pacc_d;   // saturating accumulator, capped at 2^31+1
  logic [DataW:0]   pbase_q, pbase_d; // base magnitude
  logic [DataW-1:0] pexp_q, pexp_d;
  logic             pneg_q, pneg_d;
  logic [DataW-1:0] labs, rabs;
  logic [DataW:0]   rtry;
  logic [2*DataW+1:0] prod;
  logic [DataW:0]   pmag;

  assign labs = left_i[DataW-1]  ? (~left_i + 1'b1)  : left_i;
  assign rabs = right_i[DataW-1] ? (~right_i + 1'b1) : right_i;
  assign rtry = {rem_q, quo_q[DataW-1]} - {1'b0, dvs_q};
  assign prod = pacc_q * pbase_q;
  assign pmag = (pacc_q > {1'b0, 32'h8000_0000}) ? {1'b0, 32'h8000_0001} : pacc_q;

  always_comb begin
    st_d = st_q; res_d = res_q; quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q;
    cnt_d = cnt_q; qneg_d = qneg_q; pacc_d = pacc_q; pbase_d = pbase_q;
    pexp_d = pexp_q; pneg_d = pneg_q;
    case (st_q)
      A_IDLE: if (start_i) begin
        case (op_i)
          OP_ADD: begin res_d = left_i + right_i; st_d = A_DONE; end
          OP_SUB: begin res_d = left_i - right_i; st_d = A_DONE; end
          OP_MUL: begin res_d = left_i * right_i; st_d = A_DONE; end
          OP_DIV: begin
            quo_d = labs; rem_d = '0; dvs_d = rabs; cnt_d = 6'(DataW);
            qneg_d = left_i[DataW-1] ^ right_i[DataW-1]; st_d = A_DIV;
          end
          default: begin
            pneg_d = left_i[DataW-1] & right_i[0];
            pbase_d = {1'b0, labs}; pexp_d = right_i; pacc_d = 33'd1;
            if (right_i[DataW-1]) begin
              res_d = (labs == '0) ? 32'h7FFF_FFFF :
                      (labs == 32'd1) ? (pneg_d ? '1 : 32'd1) : '0;
              st_d = A_DONE;
            end else if (right_i == '0) begin
              res_d = 32'd1; st_d = A_DONE;
            end else if (labs == '0) begin
              res_d = '0; st_d = A_DONE;
            end else if (labs == 32'd1) begin
              res_d = pneg_d ? '1 : 32'd1; st_d = A_DONE;
            end else st_d = A_POW;
          end
        endcase
      end
      A_DIV: begin
        if (!rtry[DataW]) begin
          rem_d = rtry[DataW-1:0]; quo_d = {quo_q[DataW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[DataW-2:0], quo_q[DataW-1]}; quo_d = {quo_q[DataW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          res_d = qneg_q ? (~quo_d + 1'b1) : quo_d; st_d = A_DONE;
        end
      end
      A_POW: begin
        // base >= 2, so 32 steps suffice to pass 2^31
        if (pexp_q == '0 || pacc_q > {1'b0, 32'h8000_0000}) begin
          if (pneg_q)
            res_d = (pmag >= {1'b0, 32'h8000_0000}) ? 32'h8000_0000 :
                    (~pmag[DataW-1:0] + 1'b1);
          else
            res_d = (pmag > {1'b0, 32'h7FFF_FFFF}) ? 32'h7FFF_FFFF : pmag[DataW-1:0];
          st_d = A_DONE;
        end else begin
          pacc_d = (prod > {33'd0, 1'b0, 32'h8000_0000}) ? {1'b0, 32'h8000_0001}
                                                          : prod[DataW:0];
          pexp_d = pexp_q - 1'b1;
        end
      end
      A_DONE: st_d = A_IDLE;
      default: st_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= A_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d; quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d; cnt_q <= cnt_d;
    qneg_q <= qneg_d; pacc_q <= pacc_d; pbase_q <= pbase_d; pexp_q <= pexp_d;
    pneg_q <= pneg_d;
  end

  assign done_o = (st_q == A_DONE);
  assign res_o  = res_q;

endmodule

>>> design/see_datapath.sv
module see_datapath import see_pkg::*; #(
  parameter int StackDepth = StackDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [SymW-1:0]  symbol_i,
  input  op_e              op_i,
  input  logic             mode_i,
  output sts_t             sts_o,
  output logic [$clog2(StackDepth+1)-1:0] sp_o,
  output logic [DataW-1:0] value_o
);

  localparam int SpW = $clog2(StackDepth+1);
  localparam int AW  = (StackDepth > 1) ? $clog2(StackDepth) : 1;

  logic [DataW-1:0] mem [StackDepth];
  logic [DataW-1:0] rdata_q, first_q, second_q, value_q;
  logic [SpW-1:0]   sp_q, sp_d;
  logic [SpW-1:0]   rd_addr;
  logic             rd_en;
  logic [DataW-1:0] left, right, alu_res;
  logic             alu_done;

  assign rd_en   = cmd_i.rd_top | cmd_i.rd_second;
  assign rd_addr = cmd_i.rd_second ? sp_q - SpW'(2) : sp_q - SpW'(1);

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[rd_addr[AW-1:0]];
    if (cmd_i.push_digit)
      mem[sp_q[AW-1:0]] <= DataW'(symbol_i - ChZero);
    else if (cmd_i.wb)
      mem[AW'(sp_q - SpW'(2))] <= alu_res;
    if (cmd_i.rd_second) first_q <= rdata_q;
    if (cmd_i.latch_second) second_q <= rdata_q;
    if (cmd_i.fin_latch) value_q <= rdata_q;
  end

  always_comb begin
    sp_d = sp_q;
    if (cmd_i.clear) sp_d = '0;
    else if (cmd_i.push_digit) sp_d = sp_q + SpW'(1);
    else if (cmd_i.wb) sp_d = sp_q - SpW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sp_q <= '0;
    else sp_q <= sp_d;
  end

  assign left  = mode_i ? second_q : first_q;
  assign right = mode_i ? first_q  : second_q;

  see_alu u_alu (
    .clk_i, .rst_ni, .start_i(cmd_i.start), .op_i, .left_i(left), .right_i(right),
    .done_o(alu_done), .res_o(alu_res)
  );

  assign sts_o.done = alu_done;
  assign sts_o.divz = (right == '0);
  assign sp_o       = sp_q;
  assign value_o    = value_q;

endmodule

>>> design/see_ctrl.sv
module see_ctrl import see_pkg::*; #(
  parameter int StackDepth = StackDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [SymW-1:0]  symbol_i,
  input  logic             last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [StatW-1:0] status_o,
  input  sts_t             sts_i,
  input  logic [$clog2(StackDepth+1)-1:0] sp_i,
  output cmd_t             cmd_o,
  output op_e              op_o
);

  localparam int SpW = $clog2(StackDepth+1);

  state_e  st_q, st_d;
  status_e err_q, err_d;
  op_e     op_q;
  logic    last_q;
  logic    acc;
  logic    is_digit, is_op;
  op_e     op_dec;
  logic    fin_empty;

  assign acc = in_valid_i & in_ready_o;
  assign is_digit = (symbol_i >= ChZero) && (symbol_i <= ChNine);
  assign is_op = (symbol_i == ChPlus) || (symbol_i == ChMinus) || (symbol_i == ChSlash) ||
                 (symbol_i == ChStar) || (symbol_i == ChCaret);
  assign fin_empty = (sp_i == '0);

  always_comb begin
    case (symbol_i)
      ChPlus:  op_dec = OP_ADD;
      ChMinus: op_dec = OP_SUB;
      ChStar:  op_dec = OP_MUL;
      ChSlash: op_dec = OP_DIV;
      default: op_dec = OP_POW;
    endcase
  end

  // next state
  always_comb begin
    st_d = st_q;
    err_d = err_q;
    case (st_q)
      S_IDLE: if (acc) begin
        if (err_q != ST_OK) st_d = last_i ? S_FINRD : S_IDLE;
        else if (is_digit) begin
          if (sp_i >= SpW'(StackDepth)) err_d = ST_OVER;
          st_d = last_i ? S_FINRD : S_IDLE;
        end else if (!is_op) begin
          err_d = ST_INVALID;
          st_d = last_i ? S_FINRD : S_IDLE;
        end else if (sp_i < SpW'(2)) begin
          err_d = ST_UNDER;
          st_d = last_i ? S_FINRD : S_IDLE;
        end else st_d = S_RD1;
      end
      S_RD1: st_d = S_RD2;
      S_RD2: st_d = S_LAT;
      S_LAT: st_d = S_EXEC;
      S_EXEC: begin
        if (op_q == OP_DIV && sts_i.divz) begin
          err_d = ST_DIVZERO;
          st_d = last_q ? S_FINRD : S_IDLE;
        end else st_d = S_WAIT;
      end
      S_WAIT: if (sts_i.done) st_d = S_WB;
      S_WB: st_d = last_q ? S_FINRD : S_IDLE;
      S_FINRD: st_d = S_FINWAIT;
      S_FINWAIT: st_d = S_OUT;
      S_OUT: if (out_ready_i) begin
        st_d = S_IDLE;
        err_d = ST_OK;
      end
      default: st_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    in_ready_o = (st_q == S_IDLE);
    out_valid_o = (st_q == S_OUT);
    case (st_q)
      S_IDLE: cmd_o.push_digit = acc && err_q == ST_OK && is_digit &&
                                 sp_i < SpW'(StackDepth);
      S_RD1: cmd_o.rd_top = 1'b1;
      S_RD2: cmd_o.rd_second = 1'b1;
      S_LAT: cmd_o.latch_second = 1'b1;
      S_EXEC: cmd_o.start = !(op_q == OP_DIV && sts_i.divz);
      S_WB: cmd_o.wb = 1'b1;
      S_FINRD: cmd_o.rd_top = 1'b1;
      S_FINWAIT: cmd_o.fin_latch = 1'b1;
      S_OUT: cmd_o.clear = out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      err_q <= ST_OK;
    end else begin
      st_q <= st_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      op_q <= op_dec;
      last_q <= last_i;
    end
  end

  always_comb begin
    if (err_q != ST_OK) status_o = err_q;
    else if (fin_empty) status_o = ST_EMPTY;
    else status_o = ST_OK;
  end

  assign op_o = op_q;

endmodule

>>> design/stack_expression_evaluator_unit.sv
// Stack expression evaluator: one character per request, one result per expression.
// A / runs one quotient bit per cycle in the shared ALU and ^ one multiply per cycle.
// After the last character the top of the stack is read; the result is offered after that.
// One item at a time. Reset (rst_ni low, asynchronous) empties the stack, clears the
// error and sets postfix mode; stack entries themselves are not cleared.
module stack_expression_evaluator_unit import see_pkg::*; #(
  parameter int StackDepth = StackDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i,
  see_sym_if.sink   in_if,
  see_res_if.source out_if
);

  localparam int SpW = $clog2(StackDepth+1);

  logic             mode_q;
  cmd_t             cmd;
  sts_t             sts;
  op_e              op;
  logic [SpW-1:0]   sp;
  logic [DataW-1:0] value;
  logic [StatW-1:0] status;

  // hold notation mode; the user must write it only while idle, the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= 1'b1;
    else if (cfg_we_i) mode_q <= cfg_wdata_i;
  end

  see_ctrl #(.StackDepth(StackDepth)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .symbol_i(in_if.symbol), .last_i(in_if.last),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .status_o(status), .sts_i(sts), .sp_i(sp), .cmd_o(cmd), .op_o(op)
  );

  see_datapath #(.StackDepth(StackDepth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .symbol_i(in_if.symbol), .op_i(op),
    .mode_i(mode_q), .sts_o(sts), .sp_o(sp), .value_o(value)
  );

  // empty stack reports zero
  assign out_if.value  = (sp == '0) ? '0 : value;
  assign out_if.status = status;

  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("input taken while result pending");
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp <= SpW'(StackDepth)) else $error("stack pointer beyond depth");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready) |=> (sp == '0)) else $error("stack not cleared");

endmodule
